FILE: rtl/mono_framebuffer_draw_and_flush_macros.svh
// Assertion macros for the mono framebuffer checker.
// Depends on nothing; expects i_clk and i_rst_n in the including scope.
`ifndef MONO_FRAMEBUFFER_DRAW_AND_FLUSH_MACROS_SVH
`define MONO_FRAMEBUFFER_DRAW_AND_FLUSH_MACROS_SVH

// Checked only outside reset
`define MFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define MFD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/mfd_pkg.sv
// Shared types, codes, constants and the 5x7 font for the mono framebuffer.
// Depends on nothing.
package mfd_pkg;

    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_ROWS_DEF    = 64;
    localparam int CHUNK_BYTES_DEF = 16;
    localparam int HDR_BYTES       = 3;

    localparam logic [7:0] WIDTH_RST     = 8'd128;
    localparam logic [6:0] HEIGHT_RST    = 7'd64;
    localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
    localparam logic [7:0] COL_LO_MASK   = 8'h0F;
    localparam logic [7:0] COL_HI_BASE   = 8'h10;

    typedef enum logic [2:0] {
        CMD_CLEAR   = 3'd0,
        CMD_PIXEL   = 3'd1,
        CMD_FILL    = 3'd2,
        CMD_OUTLINE = 3'd3,
        CMD_GLYPH   = 3'd4,
        CMD_BOLD    = 3'd5,
        CMD_EMPH    = 3'd6,
        CMD_PRESENT = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        REG_WIDTH   = 2'd0,
        REG_HEIGHT  = 2'd1,
        REG_COL_OFF = 2'd2,
        REG_READY   = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        J_CLEAR,
        J_DRAW,
        J_PRESENT
    } t_kind;

    // How a walked pixel is written
    typedef enum logic [1:0] {
        W_ALL,        // every pixel, value from pixel_on
        W_BORDER,     // only the rectangle border
        W_GLYPH,      // lit glyph pixels only, set
        W_GLYPH_ALL   // every glyph pixel, lit or unlit
    } t_wmode;

    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_CLEAR,
        B_WALK,
        B_RMW,
        B_PRES,
        B_PRES_RD,
        B_DONE
    } t_bstate;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [11:0] x_pos;
        logic signed [11:0] y_pos;
        logic [7:0]         rect_width;
        logic [7:0]         rect_height;
        logic               pixel_on;
        logic [7:0]         char_code;
        logic [3:0]         glyph_scale;
    } t_item;

    typedef struct packed {
        logic       status;
        logic       byte_valid;
        logic       byte_kind;
        logic [7:0] out_byte;
        logic       chunk_end;
        logic       frame_end;
    } t_result;

    // Effective configuration seen by the back end
    typedef struct packed {
        logic [8:0] eff_w;
        logic [7:0] eff_h;
        logic [7:0] col_off;
        logic       ready;
    } t_cfg;

    // Classified command; the walk covers nc x nr cells of sc x sc pixels, npass times
    typedef struct packed {
        t_kind              kind;
        t_wmode             wmode;
        logic               on;
        logic signed [13:0] bx;
        logic signed [13:0] by;
        logic [7:0]         nc;
        logic [7:0]         nr;
        logic [3:0]         sc;
        logic [1:0]         npass;
        logic [34:0]        glyph;
    } t_job;

    // Bit c*7+r holds row r of glyph column c
    function automatic logic [34:0] glyph_cols(input logic [7:0] c0, input logic [7:0] c1,
                                               input logic [7:0] c2, input logic [7:0] c3,
                                               input logic [7:0] c4);
        return {c4[6:0], c3[6:0], c2[6:0], c1[6:0], c0[6:0]};
    endfunction

    function automatic logic [34:0] font_glyph(input logic [7:0] code);
        logic [34:0] g;
        g = '0;
        case (code)
            8'h2D: g = glyph_cols(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
            8'h3A: g = glyph_cols(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
            8'h2E: g = glyph_cols(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
            8'h2F: g = glyph_cols(8'h20, 8'h10, 8'h08, 8'h04, 8'h02);
            8'h30: g = glyph_cols(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
            8'h31: g = glyph_cols(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
            8'h32: g = glyph_cols(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
            8'h33: g = glyph_cols(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
            8'h34: g = glyph_cols(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
            8'h35: g = glyph_cols(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
            8'h36: g = glyph_cols(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
            8'h37: g = glyph_cols(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
            8'h38: g = glyph_cols(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h39: g = glyph_cols(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
            8'h41: g = glyph_cols(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
            8'h42: g = glyph_cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h43: g = glyph_cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
            8'h44: g = glyph_cols(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
            8'h45: g = glyph_cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
            8'h46: g = glyph_cols(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
            8'h47: g = glyph_cols(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A);
            8'h48: g = glyph_cols(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
            8'h49: g = glyph_cols(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
            8'h4B: g = glyph_cols(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
            8'h4C: g = glyph_cols(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
            8'h4D: g = glyph_cols(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
            8'h4E: g = glyph_cols(8'h7F, 8'h02, 8'h0C, 8'h10, 8'h7F);
            8'h4F: g = glyph_cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
            8'h50: g = glyph_cols(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
            8'h51: g = glyph_cols(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
            8'h52: g = glyph_cols(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
            8'h53: g = glyph_cols(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
            8'h54: g = glyph_cols(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
            8'h55: g = glyph_cols(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
            8'h56: g = glyph_cols(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
            8'h57: g = glyph_cols(8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F);
            8'h58: g = glyph_cols(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
            8'h59: g = glyph_cols(8'h03, 8'h04, 8'h78, 8'h04, 8'h03);
            default: g = '0;   // space and unsupported codes are blank
        endcase
        return g;
    endfunction

endpackage

FILE: rtl/mfd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module mfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/mfd_fifo.sv
// Two-entry job queue between the front end and the drawing back end.
// Depends on mfd_pkg.
module mfd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mfd_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_nonempty,
    output mfd_pkg::t_job o_job
);
    import mfd_pkg::*;

    t_job       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full     = (r_cnt == 2'd2);
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_job      = r_slot[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end
endmodule

FILE: rtl/mfd_front.sv
// Front end: configuration registers, input handshake and command classification.
// Depends on mfd_pkg.
module mfd_front #(
    parameter int MAX_COLUMNS = mfd_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = mfd_pkg::MAX_ROWS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mfd_pkg::t_item i_item,
    output logic           o_stall,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    input  logic           i_full,
    input  logic           i_init_busy,
    output logic           o_push,
    output mfd_pkg::t_job  o_job,
    output mfd_pkg::t_cfg  o_cfg
);
    import mfd_pkg::*;

    logic [7:0]  r_aw;
    logic [6:0]  r_ah;
    logic [7:0]  r_coff;
    logic        r_rdy;
    logic        w_wr;
    logic [3:0]  w_scale;
    logic [34:0] w_glyph;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aw   <= WIDTH_RST;
            r_ah   <= HEIGHT_RST;
            r_coff <= 8'd0;
            r_rdy  <= 1'b0;
        end else if (w_wr) begin
            unique case (t_reg'(paddr[3:2]))
                REG_WIDTH:   r_aw   <= pwdata[7:0];
                REG_HEIGHT:  r_ah   <= pwdata[6:0];
                REG_COL_OFF: r_coff <= pwdata[7:0];
                REG_READY:   r_rdy  <= pwdata[0];
                default:     r_rdy  <= r_rdy;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (t_reg'(paddr[3:2]))
            REG_WIDTH:   prdata = {24'd0, r_aw};
            REG_HEIGHT:  prdata = {25'd0, r_ah};
            REG_COL_OFF: prdata = {24'd0, r_coff};
            REG_READY:   prdata = {31'd0, r_rdy};
            default:     prdata = 32'd0;
        endcase
    end

    // zero or oversize width/height fall back to the store size
    always_comb begin
        o_cfg.eff_w   = (r_aw == 8'd0 || 9'(r_aw) > 9'(MAX_COLUMNS)) ?
                        9'(MAX_COLUMNS) : 9'(r_aw);
        o_cfg.eff_h   = (r_ah == 7'd0 || 8'(r_ah) > 8'(MAX_ROWS)) ?
                        8'(MAX_ROWS) : 8'(r_ah);
        o_cfg.col_off = r_coff;
        o_cfg.ready   = r_rdy;
    end

    // handshake: hold off while the queue is full or the store is being swept after reset
    assign o_stall = i_full || i_init_busy;
    assign o_push  = i_valid && !o_stall;

    assign w_scale = (i_item.glyph_scale == 4'd0) ? 4'd1 : i_item.glyph_scale;
    assign w_glyph = font_glyph(i_item.char_code);

    // classify the command into a walk description
    always_comb begin
        o_job.kind  = J_DRAW;
        o_job.wmode = W_ALL;
        o_job.on    = i_item.pixel_on;
        o_job.bx    = 14'(i_item.x_pos);
        o_job.by    = 14'(i_item.y_pos);
        o_job.nc    = 8'd1;
        o_job.nr    = 8'd1;
        o_job.sc    = 4'd1;
        o_job.npass = 2'd1;
        o_job.glyph = w_glyph;
        unique case (t_cmd'(i_item.cmd))
            CMD_CLEAR: begin
                o_job.kind = J_CLEAR;
            end
            CMD_PIXEL: begin
                o_job.wmode = W_ALL;
            end
            CMD_FILL: begin
                o_job.nc = i_item.rect_width;
                o_job.nr = i_item.rect_height;
            end
            CMD_OUTLINE: begin
                o_job.wmode = W_BORDER;
                o_job.nc    = i_item.rect_width;
                o_job.nr    = i_item.rect_height;
                // a zero-width outline still draws columns x-1 and x
                if (i_item.rect_width == 8'd0 && i_item.rect_height != 8'd0) begin
                    o_job.bx = 14'(i_item.x_pos) - 14'sd1;
                    o_job.nc = 8'd2;
                end
                // a zero-height outline still draws rows y-1 and y
                if (i_item.rect_height == 8'd0 && i_item.rect_width != 8'd0) begin
                    o_job.by = 14'(i_item.y_pos) - 14'sd1;
                    o_job.nr = 8'd2;
                end
            end
            CMD_GLYPH, CMD_BOLD: begin
                o_job.wmode = W_GLYPH;
                o_job.nc    = 8'd5;
                o_job.nr    = 8'd7;
                o_job.sc    = w_scale;
                o_job.npass = (t_cmd'(i_item.cmd) == CMD_BOLD) ? 2'd2 : 2'd1;
            end
            CMD_EMPH: begin
                o_job.wmode = W_GLYPH_ALL;
                o_job.nc    = 8'd5;
                o_job.nr    = 8'd7;
                o_job.npass = 2'd3;
            end
            CMD_PRESENT: begin
                o_job.kind = J_PRESENT;
            end
            default: begin
                o_job.kind = J_CLEAR;
            end
        endcase
    end
endmodule

FILE: rtl/mfd_back.sv
// Back end: pixel walker with read-modify-write, clear sweep, flush stepper, output register.
// Depends on mfd_pkg and mfd_ram.
module mfd_back #(
    parameter int MAX_COLUMNS = mfd_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = mfd_pkg::MAX_ROWS_DEF,
    parameter int CHUNK_BYTES = mfd_pkg::CHUNK_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mfd_pkg::t_cfg    i_cfg,
    input  logic             i_job_ok,
    input  mfd_pkg::t_job    i_job,
    output logic             o_pop,
    output logic             o_init_busy,
    output logic             o_valid,
    output mfd_pkg::t_result o_result,
    input  logic             i_stall
);
    import mfd_pkg::*;

    localparam int PAGES = MAX_ROWS / 8;
    localparam int DEPTH = MAX_COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CKW   = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

    t_bstate r_state, n_state;
    t_job    r_job;
    t_result r_res;
    t_result r_out;
    logic    r_ovalid;

    logic [7:0]     r_c, r_r, r_u, r_v;
    logic [3:0]     r_dx, r_dy;
    logic [1:0]     r_pass;
    logic [7:0]     n_c, n_r, n_u, n_v;
    logic [3:0]     n_dx, n_dy;
    logic [1:0]     n_pass;
    logic           w_last;

    logic [AW-1:0]  r_clr;
    logic [AW-1:0]  r_addr;
    logic [7:0]     r_mask;
    logic           r_val;

    logic [PGW-1:0] r_fpage, n_fpage;
    logic [8:0]     r_fstep, n_fstep;
    logic [CKW-1:0] r_chunk, n_chunk;

    logic               w_we;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic [7:0]         w_wdata, w_rdata;
    logic               w_clr_last;
    logic               w_load;

    logic signed [13:0] w_px, w_py;
    logic               w_in;
    logic [AW-1:0]      w_paddr;
    logic [7:0]         w_pmask;
    logic [5:0]         w_gidx;
    logic               w_gbit;
    logic               w_wr;
    logic               w_val;

    logic [4:0]         w_pages;
    logic               w_over;
    logic [PGW:0]       w_pnext;
    logic [PGW-1:0]     w_page1;
    logic [8:0]         w_step1;
    logic               w_hdr;
    logic [8:0]         w_d;
    logic               w_plast;
    logic               w_clast;
    logic               w_fend;
    logic [7:0]         w_hbyte;
    logic [AW-1:0]      w_daddr;

    mfd_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_init_busy = (r_state == B_INIT);
    assign o_valid     = r_ovalid;
    assign o_result    = r_out;
    assign w_clr_last  = (r_clr == AW'(DEPTH - 1));
    assign w_load      = (r_state == B_DONE) && (!r_ovalid || !i_stall);

    // current pixel of the walk
    always_comb begin
        w_px    = r_job.bx + $signed({6'd0, r_u}) + $signed({13'd0, r_pass == 2'd1});
        w_py    = r_job.by + $signed({6'd0, r_v}) + $signed({13'd0, r_pass == 2'd2});
        w_in    = !w_px[13] && !w_py[13] && (w_px[12:0] < 13'(i_cfg.eff_w)) &&
                  (w_py[12:0] < 13'(i_cfg.eff_h));
        w_paddr = AW'(32'(w_py[12:3]) * MAX_COLUMNS + 32'(w_px[12:0]));
        w_pmask = 8'd1 << w_py[2:0];
        w_gidx  = 6'(r_c[2:0]) * 6'd7 + 6'(r_r[2:0]);
        w_gbit  = r_job.glyph[w_gidx];
        case (r_job.wmode)
            W_ALL: begin
                w_wr  = 1'b1;
                w_val = r_job.on;
            end
            W_BORDER: begin
                w_wr  = (r_u == 8'd0) || (r_u == r_job.nc - 8'd1) ||
                        (r_v == 8'd0) || (r_v == r_job.nr - 8'd1);
                w_val = r_job.on;
            end
            W_GLYPH: begin
                w_wr  = w_gbit;
                w_val = 1'b1;
            end
            default: begin
                w_wr  = 1'b1;
                w_val = w_gbit;
            end
        endcase
    end

    // walk counters: scale step, column, scale row, row, pass
    always_comb begin
        n_c = r_c; n_r = r_r; n_u = r_u; n_v = r_v;
        n_dx = r_dx; n_dy = r_dy; n_pass = r_pass;
        w_last = 1'b0;
        if (r_dx != r_job.sc - 4'd1) begin
            n_dx = r_dx + 4'd1;
            n_u  = r_u + 8'd1;
        end else if (r_c != r_job.nc - 8'd1) begin
            n_dx = 4'd0;
            n_c  = r_c + 8'd1;
            n_u  = r_u + 8'd1;
        end else begin
            n_dx = 4'd0;
            n_c  = 8'd0;
            n_u  = 8'd0;
            if (r_dy != r_job.sc - 4'd1) begin
                n_dy = r_dy + 4'd1;
                n_v  = r_v + 8'd1;
            end else if (r_r != r_job.nr - 8'd1) begin
                n_dy = 4'd0;
                n_r  = r_r + 8'd1;
                n_v  = r_v + 8'd1;
            end else begin
                n_dy   = 4'd0;
                n_r    = 8'd0;
                n_v    = 8'd0;
                n_pass = r_pass + 2'd1;
                w_last = (r_pass == r_job.npass - 2'd1);
            end
        end
    end

    // flush position, with fix-ups for registers changed mid-flush
    always_comb begin
        w_pages = 5'((9'(i_cfg.eff_h) + 9'd7) >> 3);
        w_over  = (r_fstep >= 9'(HDR_BYTES) + i_cfg.eff_w);
        w_pnext = w_over ? ({1'b0, r_fpage} + 1'b1) : {1'b0, r_fpage};
        w_page1 = (6'(w_pnext) >= 6'(w_pages)) ? '0 : PGW'(w_pnext);
        w_step1 = w_over ? 9'd0 : r_fstep;
        w_hdr   = (w_step1 < 9'(HDR_BYTES));
        w_d     = w_step1 - 9'(HDR_BYTES);
        w_plast = ((w_d + 9'd1) == i_cfg.eff_w);
        w_clast = (r_chunk == CKW'(CHUNK_BYTES - 1)) || w_plast;
        w_fend  = (6'(w_page1) + 6'd1 >= 6'(w_pages));
        w_daddr = AW'(32'(w_page1) * MAX_COLUMNS + 32'(w_d));
        case (w_step1[1:0])
            2'd0:    w_hbyte = PAGE_CMD_BASE + 8'(w_page1);
            2'd1:    w_hbyte = i_cfg.col_off & COL_LO_MASK;
            default: w_hbyte = COL_HI_BASE | {4'd0, i_cfg.col_off[7:4]};
        endcase
        n_fpage = w_page1;
        n_fstep = w_step1 + 9'd1;
        n_chunk = '0;
        if (!w_hdr) begin
            n_chunk = (r_chunk == CKW'(CHUNK_BYTES - 1)) ? '0 : r_chunk + 1'b1;
            if (w_plast) begin
                n_fpage = w_fend ? '0 : PGW'(6'(w_page1) + 6'd1);
                n_fstep = 9'd0;
                n_chunk = '0;
            end
        end
    end

    // next state and memory control
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_waddr = r_clr;
        w_wdata = 8'd0;
        w_raddr = (r_state == B_PRES) ? w_daddr : w_paddr;
        unique case (r_state)
            B_INIT: begin
                w_we = 1'b1;
                if (w_clr_last) n_state = B_IDLE;
            end
            B_IDLE: begin
                if (i_job_ok) begin
                    o_pop = 1'b1;
                    unique case (i_job.kind)
                        J_CLEAR:   n_state = B_CLEAR;
                        J_PRESENT: n_state = B_PRES;
                        default:   n_state = (i_job.nc == 8'd0 || i_job.nr == 8'd0) ?
                                             B_DONE : B_WALK;
                    endcase
                end
            end
            B_CLEAR: begin
                w_we = 1'b1;
                if (w_clr_last) n_state = B_DONE;
            end
            B_WALK: begin
                if (w_wr && w_in) n_state = B_RMW;
                else if (w_last)  n_state = B_DONE;
            end
            B_RMW: begin
                w_we    = 1'b1;
                w_waddr = r_addr;
                w_wdata = r_val ? (w_rdata | r_mask) : (w_rdata & ~r_mask);
                n_state = w_last ? B_DONE : B_WALK;
            end
            B_PRES: begin
                if (!i_cfg.ready || w_hdr) n_state = B_DONE;
                else                       n_state = B_PRES_RD;
            end
            B_PRES_RD: begin
                n_state = B_DONE;
            end
            B_DONE: begin
                if (w_load) n_state = B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_INIT;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_fpage  <= '0;
            r_fstep  <= 9'd0;
            r_chunk  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == B_INIT || r_state == B_CLEAR) begin
                r_clr <= w_clr_last ? '0 : r_clr + 1'b1;
            end
            if (r_state == B_PRES && i_cfg.ready) begin
                r_fpage <= n_fpage;
                r_fstep <= n_fstep;
                r_chunk <= n_chunk;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // job, walk and result datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_res  <= '0;
            r_c    <= 8'd0;
            r_r    <= 8'd0;
            r_u    <= 8'd0;
            r_v    <= 8'd0;
            r_dx   <= 4'd0;
            r_dy   <= 4'd0;
            r_pass <= 2'd0;
        end
        if ((r_state == B_WALK && !(w_wr && w_in)) || r_state == B_RMW) begin
            r_c    <= n_c;
            r_r    <= n_r;
            r_u    <= n_u;
            r_v    <= n_v;
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_pass <= n_pass;
        end
        if (r_state == B_WALK) begin
            r_addr <= w_paddr;
            r_mask <= w_pmask;
            r_val  <= w_val;
        end
        if (r_state == B_PRES) begin
            if (!i_cfg.ready) begin
                r_res.status <= 1'b1;
            end else begin
                r_res.byte_valid <= 1'b1;
                r_res.byte_kind  <= !w_hdr;
                r_res.out_byte   <= w_hbyte;
                r_res.chunk_end  <= w_hdr ? 1'b1 : w_clast;
                r_res.frame_end  <= !w_hdr && w_plast && w_fend;
            end
        end
        if (r_state == B_PRES_RD) begin
            r_res.out_byte <= w_rdata;
        end
        if (w_load) begin
            r_out <= r_res;
        end
    end
endmodule

FILE: rtl/mono_framebuffer_draw_and_flush.sv
// Page-mode monochrome framebuffer with 5x7 text drawing and a flush byte stream.
// Usage: input items arrive on i_valid/o_stall as a t_item; every item yields exactly
// one t_result on o_valid/i_stall. Registers sit on an APB-style port (4 bytes apart).
// A front end classifies each item into a two-entry job queue; the back end runs the
// job against a one-port-write, one-port-read byte store.
// In the back end, rectangles and glyphs take one walk step per clipped or skipped
// pixel, and a walk step plus a read-modify-write step through the store per written
// pixel; clear sweeps MAX_COLUMNS*MAX_ROWS/8 bytes (1024 by default), one per cycle.
// The queue lets the next item be taken while the back end works, and the output
// register holds a finished result while the receiver stalls; the back end then waits.
// After reset the store's MAX_COLUMNS*MAX_ROWS/8 bytes (1024 by default) are swept
// to zero with o_stall high; register writes are taken meanwhile.
// Results are returned in input order.
module mono_framebuffer_draw_and_flush #(
    parameter int MAX_COLUMNS = mfd_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = mfd_pkg::MAX_ROWS_DEF,
    parameter int CHUNK_BYTES = mfd_pkg::CHUNK_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  mfd_pkg::t_item   i_item,
    output logic             o_stall,
    output logic             o_valid,
    output mfd_pkg::t_result o_result,
    input  logic             i_stall,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mfd_pkg::*;

    logic w_push, w_full, w_pop, w_nonempty, w_init_busy;
    t_job w_job_in, w_job_out;
    t_cfg w_cfg;

    mfd_front #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_item      (i_item),
        .o_stall     (o_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_full      (w_full),
        .i_init_busy (w_init_busy),
        .o_push      (w_push),
        .o_job       (w_job_in),
        .o_cfg       (w_cfg)
    );

    mfd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_job      (w_job_in),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_nonempty (w_nonempty),
        .o_job      (w_job_out)
    );

    mfd_back #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS),
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_job_ok    (w_nonempty),
        .i_job       (w_job_out),
        .o_pop       (w_pop),
        .o_init_busy (w_init_busy),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_stall     (i_stall)
    );
endmodule

FILE: rtl/mfd_checker.sv
// Port-level checker for the mono framebuffer, bound to the top level.
// Depends on mfd_pkg and mono_framebuffer_draw_and_flush_macros.svh.
`include "mono_framebuffer_draw_and_flush_macros.svh"

module mfd_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_stall,
    input logic             o_valid,
    input mfd_pkg::t_result o_result,
    input logic             i_stall
);
    import mfd_pkg::*;

    // a stalled result transaction stays put
    `MFD_ASSERT(a_hold, o_valid && i_stall |=> o_valid && $stable(o_result), "result changed while stalled")

    // reset empties the output and starts the clearing sweep with input held off
    `MFD_ASSERT_ALWAYS(a_reset, !i_rst_n |=> !o_valid && o_stall, "bad state after reset")

    // a refused present carries no byte
    `MFD_ASSERT(a_refuse, o_valid && o_result.status |-> !o_result.byte_valid && !o_result.chunk_end, "refused present carries a byte")

    // end of frame is always the closing data byte of a transaction
    `MFD_ASSERT(a_frame, o_valid && o_result.frame_end |-> o_result.byte_valid && o_result.byte_kind && o_result.chunk_end, "frame end outside a data byte")
endmodule

bind mono_framebuffer_draw_and_flush mfd_checker u_mfd_checker (.*);

FILE: bench/tb_top.sv
// Testbench for the page-mode monochrome framebuffer: drawing, clipping, glyphs and flush.
// Depends on mfd_pkg and mono_framebuffer_draw_and_flush; self-contained otherwise.
`timescale 1ns / 100ps

module tb_top;
    import mfd_pkg::*;

    localparam int NCOL   = 128;
    localparam int NPAGE  = 8;
    localparam int STORE_BYTES = NCOL * NPAGE;
    localparam int CHUNK  = 16;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    t_item       i_item = '0;
    logic        o_stall;
    logic        o_valid;
    t_result     o_result;
    logic        i_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mono_framebuffer_draw_and_flush u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_item(i_item),
        .o_stall(o_stall), .o_valid(o_valid), .o_result(o_result), .i_stall(i_stall),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the block's state
    logic [7:0] shadow_fb [STORE_BYTES];
    int unsigned flush_pg, flush_pos;
    logic [7:0] cfg_width;
    logic [6:0] cfg_height;
    logic [7:0] cfg_coloff;
    logic       cfg_ready;

    t_result expected_results[$];
    int n_items, n_results, n_errors, n_present_data;
    int send_idle_pct, recv_stall_pct;

    function automatic int vis_width();
        return (cfg_width == 0 || cfg_width > NCOL) ? NCOL : int'(cfg_width);
    endfunction

    function automatic int vis_height();
        return (cfg_height == 0 || cfg_height > 64) ? 64 : int'(cfg_height);
    endfunction

    // Font, as column bytes with bit r = row r
    function automatic logic [39:0] font_cols(input logic [7:0] code);
        case (code)
            8'h2D: return 40'h0808080808;
            8'h3A: return 40'h0036360000;
            8'h2E: return 40'h0060600000;
            8'h2F: return 40'h2010080402;
            8'h30: return 40'h3E5149453E;
            8'h31: return 40'h00427F4000;
            8'h32: return 40'h4261514946;
            8'h33: return 40'h2141454B31;
            8'h34: return 40'h1814127F10;
            8'h35: return 40'h2745454539;
            8'h36: return 40'h3C4A494930;
            8'h37: return 40'h0171090503;
            8'h38: return 40'h3649494936;
            8'h39: return 40'h064949291E;
            8'h41: return 40'h7E1111117E;
            8'h42: return 40'h7F49494936;
            8'h43: return 40'h3E41414122;
            8'h44: return 40'h7F4141221C;
            8'h45: return 40'h7F49494941;
            8'h46: return 40'h7F09090901;
            8'h47: return 40'h3E4149497A;
            8'h48: return 40'h7F0808087F;
            8'h49: return 40'h00417F4100;
            8'h4B: return 40'h7F08142241;
            8'h4C: return 40'h7F40404040;
            8'h4D: return 40'h7F020C027F;
            8'h4E: return 40'h7F020C107F;
            8'h4F: return 40'h3E4141413E;
            8'h50: return 40'h7F09090906;
            8'h51: return 40'h3E4151215E;
            8'h52: return 40'h7F09192946;
            8'h53: return 40'h4649494931;
            8'h54: return 40'h01017F0101;
            8'h55: return 40'h3F4040403F;
            8'h56: return 40'h1F2040201F;
            8'h57: return 40'h7F2018207F;
            8'h58: return 40'h6314081463;
            8'h59: return 40'h0304780403;
            default: return 40'h0;
        endcase
    endfunction

    function automatic logic [7:0] glyph_col(input logic [39:0] g, input int c);
        return g[8*(4-c) +: 8];
    endfunction

    function automatic void plot(input int x, input int y, input logic on);
        int idx;
        if (x < 0 || x >= vis_width() || y < 0 || y >= vis_height()) return;
        idx = x + (y / 8) * NCOL;
        shadow_fb[idx][y % 8] = on;
    endfunction

    function automatic void plot_scaled(input int x, input int y, input logic [39:0] g,
                                        input int s);
        for (int c = 0; c < 5; c++)
            for (int r = 0; r < 7; r++)
                if (glyph_col(g, c)[r])
                    for (int dx = 0; dx < s; dx++)
                        for (int dy = 0; dy < s; dy++)
                            plot(x + c * s + dx, y + r * s + dy, 1'b1);
    endfunction

    function automatic void plot_plain(input int x, input int y, input logic [39:0] g);
        for (int c = 0; c < 5; c++)
            for (int r = 0; r < 7; r++)
                plot(x + c, y + r, glyph_col(g, c)[r]);
    endfunction

    // Applies one command to the shadow and returns the result it causes
    function automatic t_result framebuffer_predict(input t_item it);
        t_result res;
        int x, y, w, h, s, wid, pages, d;
        logic [39:0] g;
        res = '0;
        x = int'(it.x_pos);
        y = int'(it.y_pos);
        w = int'(it.rect_width);
        h = int'(it.rect_height);
        s = (it.glyph_scale == 0) ? 1 : int'(it.glyph_scale);
        g = font_cols(it.char_code);
        case (t_cmd'(it.cmd))
            CMD_CLEAR: for (int k = 0; k < STORE_BYTES; k++) shadow_fb[k] = '0;
            CMD_PIXEL: plot(x, y, it.pixel_on);
            CMD_FILL:
                for (int j = 0; j < h; j++)
                    for (int i = 0; i < w; i++) plot(x + i, y + j, it.pixel_on);
            CMD_OUTLINE: begin
                for (int i = 0; i < w; i++) begin
                    plot(x + i, y, it.pixel_on);
                    plot(x + i, y + h - 1, it.pixel_on);
                end
                for (int j = 0; j < h; j++) begin
                    plot(x, y + j, it.pixel_on);
                    plot(x + w - 1, y + j, it.pixel_on);
                end
            end
            CMD_GLYPH: plot_scaled(x, y, g, s);
            CMD_BOLD: begin
                plot_scaled(x, y, g, s);
                plot_scaled(x + 1, y, g, s);
            end
            CMD_EMPH: begin
                plot_plain(x, y, g);
                plot_plain(x + 1, y, g);
                plot_plain(x, y + 1, g);
            end
            default: begin
                wid = vis_width();
                pages = (vis_height() + 7) / 8;
                if (!cfg_ready) begin
                    res.status = 1'b1;
                    return res;
                end
                if (flush_pos >= 3 + wid) begin
                    flush_pos = 0;
                    flush_pg++;
                end
                if (flush_pg >= pages) flush_pg = 0;
                res.byte_valid = 1'b1;
                if (flush_pos < 3) begin
                    if (flush_pos == 0) res.out_byte = PAGE_CMD_BASE + 8'(flush_pg);
                    else if (flush_pos == 1) res.out_byte = cfg_coloff & COL_LO_MASK;
                    else res.out_byte = COL_HI_BASE | {4'h0, cfg_coloff[7:4]};
                    res.chunk_end = 1'b1;
                    flush_pos++;
                end else begin
                    d = flush_pos - 3;
                    res.byte_kind = 1'b1;
                    res.out_byte = shadow_fb[flush_pg * NCOL + d];
                    if ((d + 1) % CHUNK == 0 || d + 1 == wid) res.chunk_end = 1'b1;
                    if (d + 1 == wid) begin
                        if (flush_pg + 1 >= pages) begin
                            res.frame_end = 1'b1;
                            flush_pg = 0;
                        end else begin
                            flush_pg++;
                        end
                        flush_pos = 0;
                    end else begin
                        flush_pos++;
                    end
                end
            end
        endcase
        return res;
    endfunction

    // Receiver stall, changed at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Result checker
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (expected_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result %h", o_result);
            end else begin
                exp_res = expected_results.pop_front();
                if (o_result !== exp_res) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display({"mismatch: exp st=%b v=%b k=%b b=%h ce=%b fe=%b,",
                                  " got st=%b v=%b k=%b b=%h ce=%b fe=%b"},
                            exp_res.status, exp_res.byte_valid, exp_res.byte_kind,
                            exp_res.out_byte, exp_res.chunk_end, exp_res.frame_end,
                            o_result.status, o_result.byte_valid, o_result.byte_kind,
                            o_result.out_byte, o_result.chunk_end, o_result.frame_end);
                end
            end
        end
    end

    // Sends one command and queues its expected result at acceptance
    task automatic send_command(input t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_item <= it;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        expected_results.push_back(framebuffer_predict(it));
        if (t_cmd'(it.cmd) == CMD_PRESENT && cfg_ready) n_present_data++;
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg r, input logic [31:0] v);
        i_valid <= 1'b0;
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {r, 2'b00}; pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (r)
            REG_WIDTH:   cfg_width  = v[7:0];
            REG_HEIGHT:  cfg_height = v[6:0];
            REG_COL_OFF: cfg_coloff = v[7:0];
            default:     cfg_ready  = v[0];
        endcase
    endtask

    task automatic configure(input logic [7:0] w, input logic [6:0] h, input logic [7:0] co,
                             input logic rdy);
        write_reg(REG_WIDTH, {24'h0, w});
        write_reg(REG_HEIGHT, {25'h0, h});
        write_reg(REG_COL_OFF, {24'h0, co});
        write_reg(REG_READY, {31'h0, rdy});
    endtask

    function automatic t_item make_cmd(input t_cmd c, input int x, input int y, input int w,
                                       input int h, input logic on, input logic [7:0] ch,
                                       input logic [3:0] s);
        t_item it;
        it.cmd = c; it.x_pos = 12'(x); it.y_pos = 12'(y);
        it.rect_width = 8'(w); it.rect_height = 8'(h); it.pixel_on = on;
        it.char_code = ch; it.glyph_scale = s;
        return it;
    endfunction

    function automatic t_item random_item();
        t_item it;
        int sel;
        it = '0;
        it.x_pos = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(140) - 8);
        it.y_pos = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(72) - 8);
        it.rect_width = ($urandom_range(15) == 0) ? 8'($urandom) : 8'($urandom_range(12));
        it.rect_height = ($urandom_range(15) == 0) ? 8'($urandom) : 8'($urandom_range(12));
        it.pixel_on = $urandom_range(3) != 0;
        it.char_code = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h59, 8'h2D));
        it.glyph_scale = ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(2));
        sel = $urandom_range(99);
        if (sel < 1) it.cmd = CMD_CLEAR;
        else if (sel < 55) it.cmd = CMD_PRESENT;
        else it.cmd = 3'($urandom_range(6, 1));
        return it;
    endfunction

    task automatic test_directed();
        configure(8'd128, 7'd64, 8'h00, 1'b0);
        send_command(make_cmd(CMD_PRESENT, 0, 0, 0, 0, 0, 0, 0));   // refused, not ready
        drain();
        write_reg(REG_READY, 32'h1);
        send_command(make_cmd(CMD_PIXEL, 0, 0, 0, 0, 1, 0, 0));
        send_command(make_cmd(CMD_PIXEL, 127, 63, 0, 0, 1, 0, 0));
        send_command(make_cmd(CMD_PIXEL, -2048, 2047, 0, 0, 1, 0, 0));
        send_command(make_cmd(CMD_FILL, -3, -3, 8, 8, 1, 0, 0));
        send_command(make_cmd(CMD_FILL, 10, 10, 0, 5, 1, 0, 0));
        send_command(make_cmd(CMD_FILL, 2, 2, 2, 2, 0, 0, 0));
        send_command(make_cmd(CMD_OUTLINE, 20, 20, 10, 6, 1, 0, 0));
        send_command(make_cmd(CMD_OUTLINE, 40, 30, 1, 1, 1, 0, 0));
        send_command(make_cmd(CMD_GLYPH, 50, 0, 0, 0, 0, 8'h30, 4'd0));
        send_command(make_cmd(CMD_GLYPH, 60, 8, 0, 0, 0, 8'h41, 4'd3));
        send_command(make_cmd(CMD_GLYPH, 120, 60, 0, 0, 0, 8'hFF, 4'd15));
        send_command(make_cmd(CMD_BOLD, 70, 40, 0, 0, 0, 8'h57, 4'd1));
        send_command(make_cmd(CMD_EMPH, 90, 50, 0, 0, 0, 8'h38, 4'd0));
        send_command(make_cmd(CMD_EMPH, 2047, -2048, 255, 255, 1, 8'h20, 4'd15));
        for (int k = 0; k < 8; k++)
            send_command(make_cmd(CMD_PRESENT, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        drain();
    endtask

    // Random commands under one configuration and handshake mix
    task automatic test_random(input int count, input int idle, input int stall,
                               input logic [7:0] w, input logic [6:0] h, input logic [7:0] co,
                               input logic rdy);
        configure(w, h, co, rdy);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < count; k++) send_command(random_item());
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // Registers changed mid-flush: position beyond page end and beyond last page
    task automatic test_midflush_change();
        configure(8'd128, 7'd64, 8'hA5, 1'b1);
        for (int k = 0; k < 300; k++) send_command(make_cmd(CMD_PRESENT, 0, 0, 0, 0, 0, 0, 0));
        drain();
        configure(8'd5, 7'd9, 8'h5A, 1'b1);
        for (int k = 0; k < 40; k++) send_command(make_cmd(CMD_PRESENT, 0, 0, 0, 0, 0, 0, 0));
        drain();
    endtask

    initial begin
        for (int k = 0; k < STORE_BYTES; k++) shadow_fb[k] = '0;
        flush_pg = 0; flush_pos = 0;
        cfg_width = WIDTH_RST; cfg_height = HEIGHT_RST; cfg_coloff = '0; cfg_ready = 1'b0;
        send_idle_pct = 0; recv_stall_pct = 0;
        n_items = 0; n_results = 0; n_errors = 0; n_present_data = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(300, 0, 0, 8'd128, 7'd64, 8'h00, 1'b1);
        test_random(300, 48, 0, 8'd1, 7'd1, 8'hFF, 1'b1);
        test_random(300, 0, 48, 8'd37, 7'd20, 8'h3C, 1'b1);
        test_random(300, 25, 25, 8'd200, 7'd0, 8'h81, 1'b1);
        test_random(100, 25, 25, 8'd64, 7'd127, 8'h10, 1'b0);
        test_midflush_change();
        $display("covered %0d commands, %0d results, %0d flush steps with panel ready",
                 n_items, n_results, n_present_data);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
